>>> hw/rtl/icdf_pkg.sv
package icdf_pkg;
    localparam int TableDepthDef = 1024;
    localparam int ValW   = 17;
    localparam int SmpW   = 28;
    localparam logic [ValW-1:0] OneQ16 = 17'h10000;

    localparam logic [1:0] CfgBins  = 2'd0;
    localparam logic [1:0] CfgLow   = 2'd1;
    localparam logic [1:0] CfgWidth = 2'd2;

    localparam logic KindLoad   = 1'b0;
    localparam logic KindSample = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [9:0]      entry_index;
        logic [ValW-1:0] cumulative_value;
        logic [ValW-1:0] uniform_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SmpW-1:0] sample_value;
        logic                   at_top_edge;
    } t_out_item;
endpackage

>>> hw/rtl/icdf_ram.sv
module icdf_ram #(
    parameter int Width = 17,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/icdf_front.sv
module icdf_front #(
    parameter int TableDepth = icdf_pkg::TableDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  icdf_pkg::t_in_item  i_item,
    // queue toward the back part, loads and samples in arrival order
    output logic                o_q_valid,
    output logic                o_q_kind,
    output logic [$clog2(TableDepth)-1:0] o_q_idx,
    output logic [16:0]         o_q_val,
    input  logic                i_q_pop
);
    import icdf_pkg::*;
    localparam int AW = $clog2(TableDepth);

    // two-entry queue of transactions: kind, table index, value or saturated draw
    logic            r_q_kind [2];
    logic [AW-1:0]   r_q_idx [2];
    logic [ValW-1:0] r_q_val [2];
    logic [1:0]      r_cnt;
    logic            r_rd;
    logic            r_wr;
    logic            accept;
    logic            push;
    logic [ValW-1:0] sat_draw;
    logic            in_range;

    assign o_busy = (r_cnt == 2'd2);
    assign accept = i_start && !o_busy;
    assign sat_draw = (i_item.uniform_value > OneQ16) ? OneQ16 : i_item.uniform_value;

    // a load past the table is taken but dropped here
    assign in_range = ({7'd0, i_item.entry_index} < 17'(TableDepth));
    assign push = accept && ((i_item.kind == KindSample) || in_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
        if (push) begin
            r_q_kind[r_wr] <= i_item.kind;
            r_q_idx[r_wr]  <= AW'(i_item.entry_index);
            r_q_val[r_wr]  <= (i_item.kind == KindSample) ? sat_draw
                                                          : i_item.cumulative_value;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_kind  = r_q_kind[r_rd];
    assign o_q_idx   = r_q_idx[r_rd];
    assign o_q_val   = r_q_val[r_rd];
endmodule

>>> hw/rtl/icdf_back.sv
module icdf_back #(
    parameter int TableDepth = icdf_pkg::TableDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  logic                i_q_kind,
    input  logic [$clog2(TableDepth)-1:0] i_q_idx,
    input  logic [16:0]         i_q_val,
    output logic                o_q_pop,
    output logic                o_we,
    output logic [$clog2(TableDepth)-1:0] o_waddr,
    output logic [16:0]         o_wdata,
    output logic [$clog2(TableDepth)-1:0] o_raddr,
    input  logic [16:0]         i_rdata,
    input  logic [10:0]         i_bins,
    input  logic [23:0]         i_low,
    input  logic [15:0]         i_width,
    output logic                o_valid,
    output icdf_pkg::t_out_item o_item
);
    import icdf_pkg::*;
    localparam int AW = $clog2(TableDepth);
    localparam int NW = $clog2(TableDepth + 2) + 1;

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StRd   = 4'd1;
    localparam logic [3:0] StCmp  = 4'd2;
    localparam logic [3:0] StRdLo = 4'd3;
    localparam logic [3:0] StGetLo= 4'd4;
    localparam logic [3:0] StGetHi= 4'd5;
    localparam logic [3:0] StDiv  = 4'd6;
    localparam logic [3:0] StMul  = 4'd7;
    localparam logic [3:0] StSum  = 4'd8;
    localparam logic [3:0] StOut  = 4'd9;

    logic [3:0]      r_st;
    logic [ValW-1:0] r_r;
    logic [NW-1:0]   r_n, r_above, r_below, r_ibin1;
    logic            r_top;
    logic [ValW-1:0] r_lo;
    logic [ValW:0]   r_den, r_rem;
    logic [ValW-1:0] r_frac;
    logic [4:0]      r_bit;
    logic [32:0]     r_prod;
    logic [SmpW-1:0] r_res;
    logic [NW-1:0]   mid;
    logic [NW-1:0]   n_sat;
    logic [ValW:0]   rem_sh;

    assign mid = NW'((r_above + r_below) >> 1);
    assign n_sat = (i_bins == 11'd0) ? NW'(1)
                 : ({{(NW > 11 ? NW-11 : 0){1'b0}}, i_bins} > NW'(TableDepth))
                   ? NW'(TableDepth) : NW'(i_bins);
    assign rem_sh = {r_rem[ValW-1:0], 1'b0};
    assign o_q_pop = (r_st == StIdle) && i_q_valid;

    // loads leave the queue in order and write the table
    assign o_we    = o_q_pop && (i_q_kind == KindLoad);
    assign o_waddr = i_q_idx;
    assign o_wdata = i_q_val;

    // table read address, sampled by the ram at the edge ending the state
    always_comb begin
        case (r_st)
            StRd:    o_raddr = AW'(mid - NW'(1));
            StRdLo:  o_raddr = (r_ibin1 == '0) ? AW'(0) : AW'(r_ibin1 - NW'(1));
            StGetLo: o_raddr = AW'(r_ibin1);
            default: o_raddr = '0;
        endcase
    end

    // sequencer: search, fetch bin edges, serial division, scale, add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= StIdle;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_st)
                StIdle: begin
                    if (i_q_valid && (i_q_kind == KindSample)) begin
                        r_r     <= i_q_val;
                        r_n     <= n_sat;
                        r_above <= n_sat + NW'(1);
                        r_below <= '0;
                        r_top   <= 1'b0;
                        r_st    <= StRd;
                    end
                end
                StRd: begin
                    if (r_above - r_below > NW'(1)) begin
                        r_st    <= StCmp;
                    end else begin
                        r_ibin1 <= r_below;
                        r_st    <= StRdLo;
                    end
                end
                StCmp: begin
                    // probe word for the address driven in StRd
                    if (r_r == i_rdata) begin
                        r_ibin1 <= mid;
                        r_st    <= StRdLo;
                    end else begin
                        if (r_r < i_rdata) r_above <= mid;
                        else               r_below <= mid;
                        r_st <= StRd;
                    end
                end
                StRdLo: begin
                    // r_ibin1 = ibin + 1 = bin index
                    if (r_ibin1 >= r_n) begin
                        r_top  <= 1'b1;
                        r_frac <= '0;
                        r_st   <= StMul;
                    end else begin
                        r_st    <= StGetLo;
                    end
                end
                StGetLo: begin
                    r_lo    <= (r_ibin1 == '0) ? '0 : i_rdata;
                    r_st    <= StGetHi;
                end
                StGetHi: begin
                    // hi arrives now
                    r_den <= {1'b0, i_rdata} - {1'b0, r_lo};
                    r_rem <= {1'b0, r_r} - {1'b0, r_lo};
                    r_bit <= 5'd16;
                    r_frac <= '0;
                    r_st  <= StDiv;
                    if (i_rdata == r_lo) begin
                        r_frac <= r_r;
                        r_st   <= StMul;
                    end else if (i_rdata < r_lo) begin
                        // negative step: positive quotient only if num also negative
                        if (r_r < r_lo) begin
                            if (r_lo - r_r >= r_lo - i_rdata) begin
                                r_frac <= OneQ16;
                                r_st   <= StMul;
                            end else begin
                                r_den <= {1'b0, r_lo} - {1'b0, i_rdata};
                                r_rem <= {1'b0, r_lo} - {1'b0, r_r};
                            end
                        end else begin
                            r_st <= StMul;
                        end
                    end else if (r_r < r_lo) begin
                        r_st <= StMul;
                    end else if (r_r - r_lo >= i_rdata - r_lo) begin
                        r_frac <= OneQ16;
                        r_st   <= StMul;
                    end
                end
                StDiv: begin
                    // restoring division, one quotient bit a cycle
                    if (rem_sh >= r_den) begin
                        r_rem  <= rem_sh - r_den;
                        r_frac <= {r_frac[ValW-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_frac <= {r_frac[ValW-2:0], 1'b0};
                    end
                    if (r_bit == 5'd1) r_st <= StMul;
                    r_bit <= r_bit - 5'd1;
                end
                StMul: begin
                    r_prod <= 33'({16'd0, i_width} * {16'd0, r_frac}) ;
                    r_st   <= StSum;
                end
                StSum: begin
                    // low + bin*w + offset, wrapped to output width
                    r_res <= SmpW'({{4{i_low[23]}}, i_low})
                           + SmpW'(r_ibin1) * SmpW'(i_width)
                           + (r_top ? '0 : SmpW'(r_prod >> 16));
                    r_st  <= StOut;
                end
                StOut: begin
                    o_valid <= 1'b1;
                    r_st    <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    assign o_item.sample_value = r_res;
    assign o_item.at_top_edge  = r_top;
endmodule

>>> hw/rtl/inverse_cdf_table_sampler.sv
// inverse cdf table sampler
// command channel: i_start with i_item is taken when o_busy is low. kind 0
// writes one table entry (ignored if the index is past the table), kind 1
// draws one sample.
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_index/i_cfg_data, write
// only while idle; index 0 bins in use, 1 axis low edge, 2 bin width.
// results: o_valid strobes one cycle with o_item per sample; the receiver
// cannot stall, so each result is shown exactly once.
// a two-entry queue sits between the command side and the sample engine and
// keeps loads and samples in order; o_busy rises only while it is full.
// steps per sample: leave the queue, a binary search of read and compare
// probes (up to log2 of the bin count plus one, 11 at 1024 bins), close the
// search, fetch the bin edges, serial division, then scale, add and show the
// result; an exact hit ends the search early, and a top-edge result or a
// quotient settled early skips the division.
// samples run one at a time; a load writes the table as it leaves the queue.
// reset clears control state and sets registers to 1024 bins, edge 0,
// width 1.0; table contents stay undefined until loaded.
module inverse_cdf_table_sampler #(
    parameter int TableDepth = icdf_pkg::TableDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  icdf_pkg::t_in_item  i_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    output logic                o_valid,
    output icdf_pkg::t_out_item o_item
);
    import icdf_pkg::*;
    localparam int AW = $clog2(TableDepth);

    logic [10:0] r_bins;
    logic [23:0] r_low;
    logic [15:0] r_width;
    logic        q_valid, q_pop, q_kind, we;
    logic [16:0] q_val, wdata, rdata;
    logic [AW-1:0] q_idx, waddr, raddr;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins  <= 11'd1024;
            r_low   <= '0;
            r_width <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgBins:  r_bins  <= i_cfg_data[10:0];
                CfgLow:   r_low   <= i_cfg_data;
                CfgWidth: r_width <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    icdf_front #(.TableDepth(TableDepth)) u_front (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_item,
        .o_q_valid(q_valid), .o_q_kind(q_kind), .o_q_idx(q_idx),
        .o_q_val(q_val), .i_q_pop(q_pop)
    );

    icdf_ram #(.Width(ValW), .Depth(TableDepth)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    icdf_back #(.TableDepth(TableDepth)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_kind(q_kind),
        .i_q_idx(q_idx), .i_q_val(q_val), .o_q_pop(q_pop),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_raddr(raddr), .i_rdata(rdata), .i_bins(r_bins), .i_low(r_low),
        .i_width(r_width), .o_valid, .o_item
    );
endmodule
